>>> rtl/pmid_pkg.sv
// shared constants and types for the periodic minimum image distance block
`default_nettype none
package pmid_pkg;
	localparam int COORD_WIDTH_DEF = 21;
	localparam int LAT_W = 63;
	localparam int DIST_W = 22;
	localparam int CLAMP_W = 23;
	localparam int SQ_W = 45;
	localparam int SUM_W = 47;
	localparam int RAD_W = 48;
	localparam int ROOT_W = 24;
	localparam int REM_W = 26;
	localparam int NUM_IMG = 27;
	localparam logic [DIST_W-1:0] DIST_MAX = '1;
	localparam int ADDR_W = 5;

	typedef enum logic [1:0] {
		REG_LAT_A = 2'd0,
		REG_LAT_B = 2'd1,
		REG_LAT_C = 2'd2,
		REG_CUTOFF = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic en;
		logic vld;
	} pipe_ctl_t;
endpackage
`default_nettype wire

>>> rtl/periodic_min_image_distance.sv
// top level: periodic minimum image distance pipeline with apb registers
//
// channel  | dir | fields
// s_axis   | in  | tdata: first_x/y/z, second_x/y/z, each COORD_WIDTH signed
// m_axis   | out | tdata: min_distance (22); tuser: is_neighbor
// apb      | in  | lattice_a @0x00, lattice_b @0x08, lattice_c @0x10, cutoff @0x18
//
// one request per cycle sustained while the output is not stalled; 8 stages of image
// differences, squares, sums and a 3-way min tree, 24 root stages, 1 output stage
// a stall at the output freezes the whole pipeline; nothing is dropped
// reset clears valid bits and the apb registers
`default_nettype none
module periodic_min_image_distance #(
	parameter int COORD_WIDTH = pmid_pkg::COORD_WIDTH_DEF
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          s_tvalid,
	output logic                         s_tready,
	// first_x, first_y, first_z, second_x, second_y, second_z, zero pad
	input  wire [((6*COORD_WIDTH+7)/8)*8-1:0] s_tdata,
	output logic                         m_tvalid,
	input  wire                          m_tready,
	// min_distance, zero pad
	output logic [23:0]                  m_tdata,
	// is_neighbor
	output logic                         m_tuser,
	input  wire                          psel,
	input  wire                          penable,
	input  wire                          pwrite,
	input  wire [pmid_pkg::ADDR_W-1:0]   paddr,
	input  wire [63:0]                   pwdata,
	output logic [63:0]                  prdata,
	output logic                         pready
);
	import pmid_pkg::*;

	localparam int W   = COORD_WIDTH;
	localparam int BW  = W + 1;
	localparam int DW  = W + 3;
	localparam int AW  = (DW > CLAMP_W) ? DW : CLAMP_W;
	localparam int EXT = (3*W > LAT_W) ? 3*W : LAT_W;
	localparam logic [AW-1:0] CLAMP = AW'(64'd4194304);

	logic [LAT_W-1:0]  lat_q [0:2];
	logic [DIST_W-1:0] cutoff_q;
	logic              wr;

	assign pready = 1'b1;
	assign wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lat_q[0] <= '0;
			lat_q[1] <= '0;
			lat_q[2] <= '0;
			cutoff_q <= '0;
		end else if (wr) begin
			case (reg_idx_t'(paddr[4:3]))
				REG_LAT_A:  lat_q[0] <= pwdata[LAT_W-1:0];
				REG_LAT_B:  lat_q[1] <= pwdata[LAT_W-1:0];
				REG_LAT_C:  lat_q[2] <= pwdata[LAT_W-1:0];
				REG_CUTOFF: cutoff_q <= pwdata[DIST_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx_t'(paddr[4:3]))
			REG_LAT_A:  prdata = 64'(lat_q[0]);
			REG_LAT_B:  prdata = 64'(lat_q[1]);
			REG_LAT_C:  prdata = 64'(lat_q[2]);
			REG_CUTOFF: prdata = 64'(cutoff_q);
			default:    prdata = '0;
		endcase
	end

	// lattice components; bits beyond the register read as zero
	logic signed [W-1:0] lat [0:2][0:2];
	for (genvar v = 0; v < 3; v++) begin : g_lat
		logic [EXT-1:0] ext;
		assign ext = EXT'(lat_q[v]);
		for (genvar k = 0; k < 3; k++) begin : g_comp
			assign lat[v][k] = $signed(ext[k*W +: W]);
		end
	end

	pipe_ctl_t ctl;
	logic      out_vld_q;
	assign ctl.en = m_tready || !out_vld_q;
	assign ctl.vld = s_tvalid && s_tready;
	assign s_tready = ctl.en;

	// stage 1: base difference per axis
	logic              vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7, vld_s8;
	logic signed [BW-1:0] base_s1 [0:2];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0; vld_s2 <= 1'b0; vld_s3 <= 1'b0; vld_s4 <= 1'b0;
			vld_s5 <= 1'b0; vld_s6 <= 1'b0; vld_s7 <= 1'b0; vld_s8 <= 1'b0;
		end else if (ctl.en) begin
			vld_s1 <= ctl.vld; vld_s2 <= vld_s1; vld_s3 <= vld_s2; vld_s4 <= vld_s3;
			vld_s5 <= vld_s4; vld_s6 <= vld_s5; vld_s7 <= vld_s6; vld_s8 <= vld_s7;
		end
	end

	for (genvar k = 0; k < 3; k++) begin : g_base
		logic signed [W-1:0] p1, p2;
		assign p1 = $signed(s_tdata[k*W +: W]);
		assign p2 = $signed(s_tdata[(3+k)*W +: W]);
		always_ff @(posedge clk) begin
			if (ctl.en) base_s1[k] <= BW'(p2) - BW'(p1);
		end
	end

	logic [SUM_W-1:0] sum_s5 [0:NUM_IMG-1];
	for (genvar i = 0; i < NUM_IMG; i++) begin : g_img
		localparam int CA = i / 9 - 1;
		localparam int CB = (i / 3) % 3 - 1;
		localparam int CC = i % 3 - 1;
		logic [SQ_W-1:0] sq_s4 [0:2];
		for (genvar k = 0; k < 3; k++) begin : g_ax
			logic signed [DW-1:0] ta, tb, tc;
			logic signed [DW-1:0] d_s2;
			logic [AW-1:0]        mag;
			logic [CLAMP_W-1:0]   cl_s3;
			logic [2*CLAMP_W-1:0] prod;
			assign ta = (CA == 0) ? '0 : (CA > 0) ? DW'(lat[0][k]) : -DW'(lat[0][k]);
			assign tb = (CB == 0) ? '0 : (CB > 0) ? DW'(lat[1][k]) : -DW'(lat[1][k]);
			assign tc = (CC == 0) ? '0 : (CC > 0) ? DW'(lat[2][k]) : -DW'(lat[2][k]);
			assign mag = d_s2[DW-1] ? AW'(-d_s2) : AW'(d_s2);
			assign prod = cl_s3 * cl_s3;
			always_ff @(posedge clk) begin
				if (ctl.en) begin
					d_s2  <= DW'(base_s1[k]) + ta + tb + tc;
					cl_s3 <= (mag > CLAMP) ? CLAMP_W'(CLAMP) : CLAMP_W'(mag);
					sq_s4[k] <= prod[SQ_W-1:0];
				end
			end
		end
		always_ff @(posedge clk) begin
			if (ctl.en)
				sum_s5[i] <= SUM_W'(sq_s4[0]) + SUM_W'(sq_s4[1]) + SUM_W'(sq_s4[2]);
		end
	end

	// registered 3-way min tree
	logic [SUM_W-1:0] min_s6 [0:8];
	logic [SUM_W-1:0] min_s7 [0:2];
	logic [SUM_W-1:0] min_s8;

	function automatic logic [SUM_W-1:0] min3(input logic [SUM_W-1:0] a,
		input logic [SUM_W-1:0] b, input logic [SUM_W-1:0] c);
		logic [SUM_W-1:0] m;
		m = (a < b) ? a : b;
		return (c < m) ? c : m;
	endfunction

	always_ff @(posedge clk) begin
		if (ctl.en) begin
			for (int j = 0; j < 9; j++)
				min_s6[j] <= min3(sum_s5[3*j], sum_s5[3*j+1], sum_s5[3*j+2]);
			for (int j = 0; j < 3; j++)
				min_s7[j] <= min3(min_s6[3*j], min_s6[3*j+1], min_s6[3*j+2]);
			min_s8 <= min3(min_s7[0], min_s7[1], min_s7[2]);
		end
	end

	pipe_ctl_t        sq_ctl;
	logic             root_vld;
	logic [ROOT_W-1:0] root;
	assign sq_ctl.en = ctl.en;
	assign sq_ctl.vld = vld_s8;

	pmid_isqrt u_isqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (sq_ctl),
		.rad    (RAD_W'(min_s8)),
		.out_vld(root_vld),
		.root   (root)
	);

	logic [DIST_W-1:0] dist_sat;
	logic [DIST_W-1:0] dist_q;
	logic              nb_q;
	assign dist_sat = (root > ROOT_W'(DIST_MAX)) ? DIST_MAX : root[DIST_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (ctl.en) begin
			out_vld_q <= root_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.en) begin
			dist_q <= dist_sat;
			nb_q   <= (dist_sat <= cutoff_q);
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = 24'(dist_q);
	assign m_tuser  = nb_q;
endmodule
`default_nettype wire

>>> rtl/pmid_isqrt.sv
// pipelined integer square root, two radicand bits per stage
`default_nettype none
module pmid_isqrt (
	input  wire                      clk,
	input  wire                      arst_n,
	input  pmid_pkg::pipe_ctl_t      ctl,
	input  wire [pmid_pkg::RAD_W-1:0] rad,
	output logic                     out_vld,
	output logic [pmid_pkg::ROOT_W-1:0] root
);
	import pmid_pkg::*;

	logic              vld_s  [0:ROOT_W];
	logic [RAD_W-1:0]  rad_s  [0:ROOT_W];
	logic [REM_W-1:0]  rem_s  [0:ROOT_W];
	logic [ROOT_W-1:0] root_s [0:ROOT_W];

	assign vld_s[0]  = ctl.vld;
	assign rad_s[0]  = rad;
	assign rem_s[0]  = '0;
	assign root_s[0] = '0;

	for (genvar j = 0; j < ROOT_W; j++) begin : g_stage
		logic [REM_W+1:0] rem_ext;
		logic [REM_W+1:0] trial;
		logic             take;
		assign rem_ext = {rem_s[j], rad_s[j][RAD_W-1 -: 2]};
		assign trial   = (REM_W+2)'({root_s[j], 2'b01});
		assign take    = rem_ext >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[j+1] <= 1'b0;
			end else if (ctl.en) begin
				vld_s[j+1] <= vld_s[j];
			end
		end

		always_ff @(posedge clk) begin
			if (ctl.en) begin
				rad_s[j+1] <= {rad_s[j][RAD_W-3:0], 2'b00};
				if (take) begin
					rem_s[j+1]  <= REM_W'(rem_ext - trial);
					root_s[j+1] <= {root_s[j][ROOT_W-2:0], 1'b1};
				end else begin
					rem_s[j+1]  <= REM_W'(rem_ext);
					root_s[j+1] <= {root_s[j][ROOT_W-2:0], 1'b0};
				end
			end
		end
	end

	assign out_vld = vld_s[ROOT_W];
	assign root    = root_s[ROOT_W];
endmodule
`default_nettype wire

>>> rtl/pmid_checker.sv
// port-level checks for the periodic minimum image distance block
`default_nettype none
module pmid_checker (
	input wire        clk,
	input wire        arst_n,
	input wire        m_tvalid,
	input wire        m_tready,
	input wire [23:0] m_tdata,
	input wire        m_tuser,
	input wire        pready
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");
	a_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[23:22] == 2'b00)
		else $error("distance padding not zero");
	a_zero_nb: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[21:0] == 22'd0 |-> m_tuser)
		else $error("zero distance not flagged neighbor");
	a_ready: assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("pready low");
endmodule

bind periodic_min_image_distance pmid_checker u_pmid_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata),
	.m_tuser (m_tuser),
	.pready  (pready)
);
`default_nettype wire

>>> bench/pmid_checker.sv
// checker: predicts minimum image distances and compares them with the output stream
`timescale 1ns / 100ps
module pmid_scoreboard (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	input  wire         s_tready,
	input  wire [127:0] s_tdata,
	input  wire         m_tvalid,
	input  wire         m_tready,
	input  wire [23:0]  m_tdata,
	input  wire         m_tuser,
	input  wire         psel,
	input  wire         penable,
	input  wire         pwrite,
	input  wire         pready,
	input  wire [4:0]   paddr,
	input  wire [63:0]  pwdata,
	output int          fail_count,
	output int          pending
);
	import pmid_pkg::*;

	logic [62:0] lat_reg [3];
	logic [21:0] cutoff;
	// expected results in request order
	logic [22:0] exp_mem [0:511];
	logic [8:0]  wr_ptr;
	logic [8:0]  rd_ptr;
	int          level;

	// component k of a lattice register, sign extended
	function automatic longint lat_comp(input logic [62:0] r, input int k);
		logic [20:0] v;
		v = r[k*21 +: 21];
		return longint'(signed'(v));
	endfunction

	function automatic longint unsigned clamp_sq(input longint d);
		longint m;
		m = d < 0 ? -d : d;
		if (m > 64'sd4194304)
			m = 64'sd4194304;
		return longint'(m) * longint'(m);
	endfunction

	function automatic longint unsigned int_sqrt(input longint unsigned n);
		longint unsigned r;
		longint unsigned b;
		r = 0;
		b = 64'd1 << 62;
		while (b > n)
			b = b >> 2;
		while (b != 0) begin
			if (n >= r + b) begin
				n = n - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	// returns {is_neighbor, min_distance}
	function automatic logic [22:0] min_image(input logic [127:0] d);
		longint p1 [3];
		longint p2 [3];
		longint img;
		longint unsigned best;
		longint unsigned sq;
		longint unsigned root_v;
		logic [20:0] f;
		best = '1;
		for (int k = 0; k < 3; k++) begin
			f = d[k*21 +: 21];
			p1[k] = longint'(signed'(f));
			f = d[(k+3)*21 +: 21];
			p2[k] = longint'(signed'(f));
		end
		for (int a = -1; a <= 1; a++)
			for (int b = -1; b <= 1; b++)
				for (int c = -1; c <= 1; c++) begin
					sq = 0;
					for (int k = 0; k < 3; k++) begin
						img = p2[k] + a * lat_comp(lat_reg[0], k)
							+ b * lat_comp(lat_reg[1], k) + c * lat_comp(lat_reg[2], k);
						sq = sq + clamp_sq(img - p1[k]);
					end
					if (sq < best)
						best = sq;
				end
		root_v = int_sqrt(best);
		if (root_v > 64'd4194303)
			root_v = 64'd4194303;
		return {root_v <= longint'(cutoff), root_v[21:0]};
	endfunction

	always @(posedge clk or negedge arst_n) begin
		logic [22:0] exp_v;
		if (!arst_n) begin
			lat_reg[0] <= '0;
			lat_reg[1] <= '0;
			lat_reg[2] <= '0;
			cutoff <= '0;
			fail_count <= 0;
			pending <= 0;
			wr_ptr = '0;
			rd_ptr = '0;
			level = 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr[4:3])
					REG_LAT_A: lat_reg[0] <= pwdata[62:0];
					REG_LAT_B: lat_reg[1] <= pwdata[62:0];
					REG_LAT_C: lat_reg[2] <= pwdata[62:0];
					REG_CUTOFF: cutoff <= pwdata[21:0];
					default: ;
				endcase
			end
			if (s_tvalid && s_tready) begin
				exp_mem[wr_ptr] = min_image(s_tdata);
				wr_ptr = wr_ptr + 9'd1;
				level = level + 1;
			end
			if (m_tvalid && m_tready) begin
				if (level == 0) begin
					$display("%0t: unexpected result dist=%0d flag=%0b", $time, m_tdata, m_tuser);
					fail_count <= fail_count + 1;
				end else begin
					exp_v = exp_mem[rd_ptr];
					rd_ptr = rd_ptr + 9'd1;
					level = level - 1;
					if (m_tdata !== {2'b00, exp_v[21:0]} || m_tuser !== exp_v[22]) begin
						$display("%0t: expected dist=%0d flag=%0b, actual dist=%0d flag=%0b",
							$time, exp_v[21:0], exp_v[22], m_tdata, m_tuser);
						fail_count <= fail_count + 1;
					end
				end
			end
			pending <= level;
		end
	end
endmodule

>>> bench/tb_periodic_min_image_distance.sv
// testbench top: stimulus, register writes and final verdict
`timescale 1ns / 100ps
module tb_periodic_min_image_distance;
	import pmid_pkg::*;

	localparam int WATCHDOG = 20000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [127:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [23:0] m_tdata;
	logic m_tuser;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [4:0] paddr = '0;
	logic [63:0] pwdata = '0;
	logic [63:0] prdata;
	logic pready;
	int fail_count;
	int pending;
	int idle_cycles = 0;
	bit calm = 1'b0;

	always #5 clk = ~clk;

	periodic_min_image_distance u_top (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	pmid_scoreboard u_checker (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
		.paddr(paddr), .pwdata(pwdata), .fail_count(fail_count), .pending(pending)
	);

	// receiver stalls at random except during the calm stretch
	always @(posedge clk) begin
		m_tready <= calm || ($urandom_range(99) >= 8);
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG) begin
			$display("status: fail");
			$finish;
		end
	end

	task automatic write_reg(input reg_idx_t idx, input logic [63:0] val);
		@(posedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= {idx, 3'b000};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	function automatic logic [62:0] pack_vec(input logic [20:0] x, input logic [20:0] y,
		input logic [20:0] z);
		return {z, y, x};
	endfunction

	function automatic logic [20:0] rand_coord(input int span);
		int v;
		if ($urandom_range(9) == 0)
			return 21'($urandom);
		v = int'($urandom_range(2 * span)) - span;
		return 21'(v);
	endfunction

	// tvalid stays high between back-to-back requests in the calm stretch; otherwise random gaps are inserted
	task automatic send_pair(input logic [20:0] c [6]);
		logic [127:0] d;
		d = '0;
		for (int k = 0; k < 6; k++)
			d[k*21 +: 21] = c[k];
		while (!calm && $urandom_range(99) < 8) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= d;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0 || m_tvalid)
			@(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic set_lattice(input int span);
		for (int r = 0; r < 3; r++) begin
			if (span == 0)
				write_reg(reg_idx_t'(r), 64'($urandom) << 32 | 64'($urandom) | 64'h1 << 63);
			else
				write_reg(reg_idx_t'(r), {1'b1, pack_vec(rand_coord(span), rand_coord(span),
					rand_coord(span))});
		end
		write_reg(REG_CUTOFF, {$urandom, $urandom});
	endtask

	initial begin
		logic [20:0] c [6];
		logic [20:0] mx;
		logic [20:0] mn;
		mx = 21'h0FFFFF;
		mn = 21'h100000;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: zero lattice first, then extremes and coincident points
		c = '{default: '0};
		send_pair(c);
		c = '{mx, mx, mx, mn, mn, mn};
		send_pair(c);
		c = '{mn, mn, mn, mx, mx, mx};
		send_pair(c);
		drain();
		write_reg(REG_LAT_A, {1'b0, pack_vec(21'd10240, 21'd0, 21'd0)});
		write_reg(REG_LAT_B, {1'b0, pack_vec(21'd0, 21'd10240, 21'd0)});
		write_reg(REG_LAT_C, {1'b0, pack_vec(21'd0, 21'd0, 21'd10240)});
		write_reg(REG_CUTOFF, 64'd3072);
		c = '{21'd100, 21'd100, 21'd100, 21'd10000, 21'd10000, 21'd10000};
		send_pair(c);
		c = '{21'd5, 21'd6, 21'd7, 21'd5, 21'd6, 21'd7};
		send_pair(c);
		c = '{21'd0, 21'd0, 21'd0, 21'd3072, 21'd0, 21'd0};
		send_pair(c);
		c = '{21'd0, 21'd0, 21'd0, 21'd3073, 21'd0, 21'd0};
		send_pair(c);
		c = '{mx, mn, mx, mn, mx, mn};
		send_pair(c);
		drain();
		write_reg(REG_LAT_A, {64{1'b1}});
		write_reg(REG_LAT_B, {1'b0, pack_vec(mn, mn, mn)});
		write_reg(REG_LAT_C, {1'b0, pack_vec(mx, mx, mx)});
		write_reg(REG_CUTOFF, {64{1'b1}});
		c = '{mx, mx, mx, mn, mn, mn};
		send_pair(c);
		c = '{mn, mx, mn, mx, mn, mx};
		send_pair(c);
		c = '{21'd1, 21'd2, 21'd3, 21'd1, 21'd2, 21'd3};
		send_pair(c);
		drain();

		// random phases with different lattice scales
		for (int ph = 0; ph < 9; ph++) begin
			set_lattice(ph == 8 ? 0 : (ph % 3 == 0 ? 1048575 : 20000));
			calm = (ph == 4);
			for (int i = 0; i < 50; i++) begin
				for (int k = 0; k < 6; k++)
					c[k] = rand_coord(ph % 2 ? 1048575 : 20000);
				if ($urandom_range(9) == 0)
					for (int k = 0; k < 3; k++)
						c[k+3] = c[k];
				send_pair(c);
			end
			calm = 1'b0;
			drain();
		end

		if (fail_count == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end
endmodule

>>> periodic_min_image_distance.f
rtl/pmid_pkg.sv
rtl/pmid_isqrt.sv
rtl/periodic_min_image_distance.sv
rtl/pmid_checker.sv
bench/pmid_checker.sv
bench/tb_periodic_min_image_distance.sv
